>>> src/sart_pkg.sv
// Shared types and constants for the stream ack and retransmit tracker.
package sart_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_HANDLE_BITS = 16;

    typedef enum logic [3:0] {
        CMD_START    = 4'd0,
        CMD_ENQUEUE  = 4'd1,
        CMD_ACK      = 4'd2,
        CMD_RESUMED  = 4'd3,
        CMD_RESEND   = 4'd4,
        CMD_HANDLED  = 4'd5,
        CMD_INCOMING = 4'd6,
        CMD_REQUEST  = 4'd7,
        CMD_RESPOND  = 4'd8,
        CMD_TAKE     = 4'd9,
        CMD_TICK     = 4'd10
    } t_cmd;

    typedef struct packed {
        logic [6:0]  queue_length;
        logic [15:0] resend_handle;
        logic        resend_valid;
        logic        request_emitted;
        logic        timer_refreshed;
        logic [31:0] count_value;
        logic [15:0] elapsed_seconds;
        logic        session_started;
        logic        session_resumed;
        logic        queue_overflow;
        logic        awaiting_ack;
    } t_result;

endpackage

>>> src/sart_ring.sv
// Pending handle ring storage: one write port, one registered read port with write bypass.
module sart_ring #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // pass a word written this cycle straight to the read register
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/sart_core.sv
// Tracker state and the single-pass update for one command word.
module sart_core
    import sart_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_proc,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_handle,
    input  logic [31:0] i_peer,
    output t_result     o_res
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int HW_MAX = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] slot_of(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] w;
        w = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return w[PTR_W-1:0];
    endfunction

    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_resend, n_resend;
    logic [31:0]      r_server, n_server;
    logic [31:0]      r_recv, n_recv;
    logic [31:0]      r_tally, n_tally;
    logic             r_started, n_started;
    logic             r_resumed, n_resumed;
    logic             r_awaiting, n_awaiting;
    logic [31:0]      r_now, n_now;
    logic [31:0]      r_mark, n_mark;
    logic             r_mark_valid, n_mark_valid;

    logic                   we;
    logic [PTR_W-1:0]       waddr;
    logic [PTR_W-1:0]       raddr;
    logic [HANDLE_BITS-1:0] wdata;
    logic [HANDLE_BITS-1:0] rd_data;
    logic [HW_MAX-1:0]      wide_in;
    logic [HW_MAX-1:0]      wide_rd;
    logic [31:0]            gap;
    logic [CNT_W-1:0]       drop;
    logic [31:0]            delta;

    sart_ring #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (HANDLE_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        wide_in = HW_MAX'(i_handle);
        wdata   = wide_in[HANDLE_BITS-1:0];
        wide_rd = HW_MAX'(rd_data);
        waddr   = slot_of(SUM_W'(r_head) + SUM_W'(r_count));
        we      = 1'b0;

        gap  = i_peer - r_server;
        drop = (gap < 32'(r_count)) ? gap[CNT_W-1:0] : r_count;

        n_head       = r_head;
        n_count      = r_count;
        n_resend     = r_resend;
        n_server     = r_server;
        n_recv       = r_recv;
        n_tally      = r_tally;
        n_started    = r_started;
        n_resumed    = r_resumed;
        n_awaiting   = r_awaiting;
        n_now        = r_now;
        n_mark       = r_mark;
        n_mark_valid = r_mark_valid;

        o_res = '0;

        if (i_proc) begin
            case (i_cmd)
                CMD_START: begin
                    n_resumed    = 1'b0;
                    n_awaiting   = 1'b0;
                    n_resend     = '0;
                    n_tally      = '0;
                    n_mark_valid = 1'b0;
                    n_started    = 1'b1;
                end
                CMD_ENQUEUE: begin
                    if (r_count >= DEPTH_C) begin
                        o_res.queue_overflow = 1'b1;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_ACK, CMD_RESUMED: begin
                    if (i_cmd == CMD_RESUMED) begin
                        n_resumed = 1'b1;
                        n_resend  = '0;
                    end
                    // drop acknowledged words from the head
                    n_awaiting   = 1'b0;
                    n_mark       = r_now;
                    n_mark_valid = 1'b1;
                    n_head       = slot_of(SUM_W'(r_head) + SUM_W'(drop));
                    n_count      = r_count - drop;
                    n_server     = r_server + 32'(drop);
                    n_tally      = r_tally + 32'(drop);
                end
                CMD_RESEND: begin
                    if (r_resend < r_count) begin
                        o_res.resend_handle = wide_rd[15:0];
                        o_res.resend_valid  = 1'b1;
                        n_resend            = r_resend + CNT_W'(1);
                    end
                end
                CMD_HANDLED: begin
                    n_recv = r_recv + 32'd1;
                end
                CMD_INCOMING: begin
                    if (r_awaiting) begin
                        n_mark                = r_now;
                        n_mark_valid          = 1'b1;
                        o_res.timer_refreshed = 1'b1;
                    end
                end
                CMD_REQUEST: begin
                    if (!r_awaiting) begin
                        n_awaiting            = 1'b1;
                        n_mark                = r_now;
                        n_mark_valid          = 1'b1;
                        o_res.request_emitted = 1'b1;
                    end
                end
                CMD_RESPOND: begin
                    o_res.count_value = r_recv;
                end
                CMD_TAKE: begin
                    o_res.count_value = r_tally;
                    n_tally           = '0;
                end
                CMD_TICK: begin
                    n_now = r_now + 32'd1;
                end
                default: begin
                end
            endcase
        end

        delta = n_now - n_mark;
        if (n_mark_valid) begin
            o_res.elapsed_seconds = (delta > 32'h0000_FFFF) ? 16'hFFFF : delta[15:0];
        end
        o_res.queue_length    = 7'(n_count);
        o_res.session_started = n_started;
        o_res.session_resumed = n_resumed;
        o_res.awaiting_ack    = n_awaiting;

        // prefetch the word the next resend would return
        raddr = slot_of(SUM_W'(n_head) + SUM_W'(n_resend));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= '0;
            r_resend     <= '0;
            r_server     <= '0;
            r_recv       <= '0;
            r_tally      <= '0;
            r_started    <= 1'b0;
            r_resumed    <= 1'b0;
            r_awaiting   <= 1'b0;
            r_now        <= '0;
            r_mark       <= '0;
            r_mark_valid <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_count      <= n_count;
            r_resend     <= n_resend;
            r_server     <= n_server;
            r_recv       <= n_recv;
            r_tally      <= n_tally;
            r_started    <= n_started;
            r_resumed    <= n_resumed;
            r_awaiting   <= n_awaiting;
            r_now        <= n_now;
            r_mark       <= n_mark;
            r_mark_valid <= n_mark_valid;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("ring count above depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.queue_overflow |-> (i_proc && (r_count == DEPTH_C)))
        else $error("overflow flagged with room in ring");

    a_resend_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && (i_cmd == CMD_RESEND) && (r_resend < r_count))
            |=> (r_resend == ($past(r_resend) + CNT_W'(1))))
        else $error("resend pointer did not advance");

    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && ((i_cmd == CMD_ACK) || (i_cmd == CMD_RESUMED)))
            |=> (!r_awaiting && r_mark_valid))
        else $error("ack left request outstanding");

endmodule

>>> src/stream_ack_retransmit_tracker.sv
// Top level: input register, tracker core and result register with valid/stall handshake.
// Words pass through the input register, then the core, then the result register.
// Throughput: one word per cycle; a stalled result holds the core, then the input register.
// The resend word is prefetched from the ring's registered read port every cycle.
// Reset (synchronous, active low) clears counters, flags, pointers and both valid bits.
// Ring contents are not cleared; a resend only returns an entry after it has been written.
module stream_ack_retransmit_tracker
    import sart_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_cmd,
    input  logic [15:0] i_item_handle,
    input  logic [31:0] i_peer_handled_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_queue_length,
    output logic [15:0] o_resend_handle,
    output logic        o_resend_valid,
    output logic        o_request_emitted,
    output logic        o_timer_refreshed,
    output logic [31:0] o_count_value,
    output logic [15:0] o_elapsed_seconds,
    output logic        o_session_started,
    output logic        o_session_resumed,
    output logic        o_queue_overflow,
    output logic        o_awaiting_ack
);

    logic        r_in_valid;
    logic [3:0]  r_cmd;
    logic [15:0] r_handle;
    logic [31:0] r_peer;
    logic        r_out_valid;
    t_result     r_res;
    t_result     res;
    logic        advance;
    logic        proc;
    logic        load_in;

    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    // fill an empty input register even while the result is held
    assign load_in    = !r_in_valid || advance;
    assign o_in_stall = r_in_valid && !advance;

    sart_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_proc   (proc),
        .i_cmd    (t_cmd'(r_cmd)),
        .i_handle (r_handle),
        .i_peer   (r_peer),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_in) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_cmd    <= i_cmd;
            r_handle <= i_item_handle;
            r_peer   <= i_peer_handled_count;
        end
        if (proc) begin
            r_res <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_queue_length    = r_res.queue_length;
    assign o_resend_handle   = r_res.resend_handle;
    assign o_resend_valid    = r_res.resend_valid;
    assign o_request_emitted = r_res.request_emitted;
    assign o_timer_refreshed = r_res.timer_refreshed;
    assign o_count_value     = r_res.count_value;
    assign o_elapsed_seconds = r_res.elapsed_seconds;
    assign o_session_started = r_res.session_started;
    assign o_session_resumed = r_res.session_resumed;
    assign o_queue_overflow  = r_res.queue_overflow;
    assign o_awaiting_ack    = r_res.awaiting_ack;

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a waiting result");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("processed word produced no result");

    a_no_result_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_valid) |=> !r_out_valid)
        else $error("result without a processed word");

endmodule

>>> bench/stream_ack_retransmit_tracker_tb.sv
// Self-checking bench for the stream ack and retransmit tracker, scoreboard included.
module stream_ack_retransmit_tracker_tb;
    import sart_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = DEF_QUEUE_DEPTH;

    class tracker_scoreboard;
        t_result     expected_q[$];
        int          mismatches = 0;
        int          results_seen = 0;
        logic [15:0] ring [RING_DEPTH];
        int          head = 0;
        int          depth_used = 0;
        int          resend_at = 0;
        logic [31:0] server_cnt = '0;
        logic [31:0] recv_total = '0;
        logic [31:0] acked = '0;
        logic [31:0] now_s = '0;
        logic [31:0] mark_s = '0;
        bit          started = 0;
        bit          resumed = 0;
        bit          awaiting = 0;
        bit          mark_ok = 0;

        function int pending();
            return expected_q.size();
        endfunction

        function void set_mark();
            mark_s = now_s;
            mark_ok = 1;
        endfunction

        // Advance the tracker state by one accepted word and queue its result.
        function void note_word(logic [3:0] c, logic [15:0] h, logic [31:0] p);
            t_result     r;
            logic [31:0] gap;
            logic [31:0] span;
            int          drop;
            r = '0;
            case (c)
                CMD_START: begin
                    resumed = 0;
                    awaiting = 0;
                    resend_at = 0;
                    acked = '0;
                    mark_ok = 0;
                    started = 1;
                end
                CMD_ENQUEUE: begin
                    if (depth_used >= RING_DEPTH) begin
                        r.queue_overflow = 1'b1;
                    end else begin
                        ring[(head + depth_used) % RING_DEPTH] = h;
                        depth_used++;
                    end
                end
                CMD_ACK, CMD_RESUMED: begin
                    if (c == CMD_RESUMED) begin
                        resumed = 1;
                        resend_at = 0;
                    end
                    // the gap wraps, so a count behind the server drains everything
                    gap = p - server_cnt;
                    drop = (gap < depth_used) ? int'(gap) : depth_used;
                    awaiting = 0;
                    set_mark();
                    head = (head + drop) % RING_DEPTH;
                    depth_used -= drop;
                    server_cnt += drop;
                    acked += drop;
                end
                CMD_RESEND: begin
                    if (resend_at < depth_used) begin
                        r.resend_handle = ring[(head + resend_at) % RING_DEPTH];
                        r.resend_valid = 1'b1;
                        resend_at++;
                    end
                end
                CMD_HANDLED: recv_total++;
                CMD_INCOMING: begin
                    if (awaiting) begin
                        set_mark();
                        r.timer_refreshed = 1'b1;
                    end
                end
                CMD_REQUEST: begin
                    if (!awaiting) begin
                        awaiting = 1;
                        set_mark();
                        r.request_emitted = 1'b1;
                    end
                end
                CMD_RESPOND: r.count_value = recv_total;
                CMD_TAKE: begin
                    r.count_value = acked;
                    acked = '0;
                end
                CMD_TICK: now_s++;
                default: ;
            endcase
            if (mark_ok) begin
                span = now_s - mark_s;
                r.elapsed_seconds = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
            end
            r.queue_length = 7'(depth_used);
            r.session_started = started;
            r.session_resumed = resumed;
            r.awaiting_ack = awaiting;
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
        endtask

        task check_word(t_result got);
            t_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("unexpected result word", 0, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.queue_length !== want.queue_length)
                report("queue_length", got.queue_length, want.queue_length);
            if (got.resend_handle !== want.resend_handle)
                report("resend_handle", got.resend_handle, want.resend_handle);
            if (got.resend_valid !== want.resend_valid)
                report("resend_valid", got.resend_valid, want.resend_valid);
            if (got.request_emitted !== want.request_emitted)
                report("request_emitted", got.request_emitted, want.request_emitted);
            if (got.timer_refreshed !== want.timer_refreshed)
                report("timer_refreshed", got.timer_refreshed, want.timer_refreshed);
            if (got.count_value !== want.count_value)
                report("count_value", got.count_value, want.count_value);
            if (got.elapsed_seconds !== want.elapsed_seconds)
                report("elapsed_seconds", got.elapsed_seconds, want.elapsed_seconds);
            if (got.session_started !== want.session_started)
                report("session_started", got.session_started, want.session_started);
            if (got.session_resumed !== want.session_resumed)
                report("session_resumed", got.session_resumed, want.session_resumed);
            if (got.queue_overflow !== want.queue_overflow)
                report("queue_overflow", got.queue_overflow, want.queue_overflow);
            if (got.awaiting_ack !== want.awaiting_ack)
                report("awaiting_ack", got.awaiting_ack, want.awaiting_ack);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [3:0]  i_cmd;
    logic [15:0] i_item_handle;
    logic [31:0] i_peer_handled_count;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [6:0]  o_queue_length;
    logic [15:0] o_resend_handle;
    logic        o_resend_valid;
    logic        o_request_emitted;
    logic        o_timer_refreshed;
    logic [31:0] o_count_value;
    logic [15:0] o_elapsed_seconds;
    logic        o_session_started;
    logic        o_session_resumed;
    logic        o_queue_overflow;
    logic        o_awaiting_ack;

    t_result           got;
    tracker_scoreboard sb;
    bit                idle_on = 0;
    bit                hold_active = 0;
    int                burst_left = 0;

    stream_ack_retransmit_tracker u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_cmd                (i_cmd),
        .i_item_handle        (i_item_handle),
        .i_peer_handled_count (i_peer_handled_count),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_queue_length       (o_queue_length),
        .o_resend_handle      (o_resend_handle),
        .o_resend_valid       (o_resend_valid),
        .o_request_emitted    (o_request_emitted),
        .o_timer_refreshed    (o_timer_refreshed),
        .o_count_value        (o_count_value),
        .o_elapsed_seconds    (o_elapsed_seconds),
        .o_session_started    (o_session_started),
        .o_session_resumed    (o_session_resumed),
        .o_queue_overflow     (o_queue_overflow),
        .o_awaiting_ack       (o_awaiting_ack)
    );

    always #6 i_clk = ~i_clk;

    assign got = {o_queue_length, o_resend_handle, o_resend_valid, o_request_emitted,
                  o_timer_refreshed, o_count_value, o_elapsed_seconds, o_session_started,
                  o_session_resumed, o_queue_overflow, o_awaiting_ack};

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(got);
    end

    // Receiver: random stall bursts, plus the long hold-off when requested.
    always @(negedge i_clk) begin
        if (burst_left == 0 && idle_on && $urandom_range(0, 9) == 0)
            burst_left = $urandom_range(1, 7);
        i_out_stall <= hold_active || burst_left > 0;
        if (burst_left > 0)
            burst_left--;
    end

    initial begin
        #(64'd60_000_000);
        $display("[stream_ack_retransmit_tracker] ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance with valid
    // still high, so the caller either offers the next word or drops valid right away.
    task automatic send_word(logic [3:0] c, logic [15:0] h, logic [31:0] p);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= c;
        i_item_handle <= h;
        i_peer_handled_count <= p;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_word(c, h, p);
        @(negedge i_clk);
    endtask

    task automatic send_random_word();
        logic [3:0]  c;
        logic [15:0] h;
        logic [31:0] p;
        int          pick;
        pick = $urandom_range(0, 99);
        h = 16'($urandom());
        p = $urandom();
        if (pick < 30)      c = CMD_ENQUEUE;
        else if (pick < 42) c = CMD_ACK;
        else if (pick < 45) c = CMD_RESUMED;
        else if (pick < 57) c = CMD_RESEND;
        else if (pick < 62) c = CMD_HANDLED;
        else if (pick < 67) c = CMD_INCOMING;
        else if (pick < 73) c = CMD_REQUEST;
        else if (pick < 77) c = CMD_RESPOND;
        else if (pick < 81) c = CMD_TAKE;
        else if (pick < 93) c = CMD_TICK;
        else if (pick < 96) c = CMD_START;
        else                c = 4'(CMD_TICK + $urandom_range(1, 5));
        if (c == CMD_ACK || c == CMD_RESUMED) begin
            case ($urandom_range(0, 9))
                0: ;
                1: p = sb.server_cnt - 32'($urandom_range(1, 5));
                default: p = sb.server_cnt + 32'($urandom_range(0, sb.depth_used + 2));
            endcase
        end
        send_word(c, h, p);
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic hold_receiver(int cycles);
        @(posedge i_clk);
        hold_active = 1;
        repeat (cycles) @(posedge i_clk);
        hold_active = 0;
    endtask

    initial begin
        sb = new;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_START;
        i_item_handle = '0;
        i_peer_handled_count = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corner cases
        send_word(CMD_TICK, 16'h1234, 32'h0);
        send_word(CMD_START, 16'h0, 32'h0);
        send_word(CMD_ENQUEUE, 16'h0000, 32'h0);
        send_word(CMD_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_ENQUEUE, 16'hA5A5, 32'h0);
        repeat (4) send_word(CMD_RESEND, 16'h0, 32'h0);
        send_word(CMD_REQUEST, 16'h0, 32'h0);
        send_word(CMD_REQUEST, 16'h0, 32'h0);
        send_word(CMD_TICK, 16'h0, 32'h0);
        send_word(CMD_INCOMING, 16'h0, 32'h0);
        send_word(CMD_ACK, 16'h0, 32'd1);
        send_word(CMD_INCOMING, 16'h0, 32'h0);
        send_word(CMD_RESEND, 16'h0, 32'h0);
        send_word(CMD_HANDLED, 16'h0, 32'h0);
        send_word(CMD_HANDLED, 16'h0, 32'h0);
        send_word(CMD_RESPOND, 16'h0, 32'h0);
        send_word(CMD_TAKE, 16'h0, 32'h0);
        send_word(CMD_TAKE, 16'h0, 32'h0);
        send_word(CMD_ACK, 16'h0, 32'h0);
        send_word(CMD_ACK, 16'h0, sb.server_cnt);
        send_word(CMD_RESUMED, 16'h0, 32'hFFFF_FFFF);
        send_word(4'(CMD_TICK + 1), 16'hFFFF, 32'hFFFF_FFFF);
        send_word(4'(CMD_TICK + 5), 16'h0, 32'h0);
        send_word(CMD_START, 16'h0, 32'h0);

        // fill past full, walk the whole ring, then resume partway
        idle_on = 1;
        repeat (RING_DEPTH + 2) send_word(CMD_ENQUEUE, 16'($urandom()), $urandom());
        repeat (RING_DEPTH + 1) send_word(CMD_RESEND, 16'h0, 32'h0);
        send_word(CMD_RESUMED, 16'h0, sb.server_cnt + 32'd10);
        repeat (3) send_word(CMD_RESEND, 16'h0, 32'h0);
        send_word(CMD_TAKE, 16'h0, 32'h0);
        send_word(CMD_ACK, 16'h0, sb.server_cnt + 32'd100);
        drain_results();
        @(negedge i_clk);

        // long receiver hold-off while the sender keeps offering words
        idle_on = 0;
        fork
            hold_receiver(250);
        join_none
        repeat (60) send_random_word();
        drain_results();
        @(negedge i_clk);

        idle_on = 1;
        repeat (300) send_random_word();
        idle_on = 0;
        repeat (150) send_random_word();
        idle_on = 1;
        repeat (200) send_random_word();
        drain_results();
        @(negedge i_clk);

        // back to back to the end
        idle_on = 0;
        repeat (100) send_random_word();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[stream_ack_retransmit_tracker] OK");
        else
            $display("[stream_ack_retransmit_tracker] ERROR");
        $finish;
    end

endmodule

>>> files.f
src/sart_pkg.sv
src/sart_ring.sv
src/sart_core.sv
src/stream_ack_retransmit_tracker.sv
bench/stream_ack_retransmit_tracker_tb.sv
